// File: hdl/vrp_pkg.sv
// Shared types, constants and address-decode functions of the video register port.
// Used by vrp_vram and video_register_port_with_vram; depends on nothing else.
package vrp_pkg;

    localparam int NAMETABLE_BYTES  = 2048;
    localparam int PATTERN_BYTES    = 8192;
    localparam int SPRITE_MEM_BYTES = 256;
    localparam int PALETTE_BYTES    = 32;

    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);
    localparam int VA_W   = 14;

    // Opcodes of a transaction.
    localparam logic [1:0] OP_READ      = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_VBLANK    = 2'd2;
    localparam logic [1:0] OP_PRERENDER = 2'd3;

    // Register numbers.
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SPR_ADR = 3'd3;
    localparam logic [2:0] REG_SPR_DAT = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // Nametable mirroring modes.
    localparam logic [1:0] MIR_HORIZ  = 2'd0;
    localparam logic [1:0] MIR_VERT   = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_addr;
        logic [7:0] wdata;
        logic [8:0] scanline;
    } vrp_in_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       nmi_raise;
    } vrp_out_t;

    typedef struct packed {
        logic            rd_en;
        logic            wr_en;
        logic [VA_W-1:0] addr;
        logic [7:0]      wdata;
        logic [1:0]      mirroring;
    } vram_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] nt_data;
        logic       clearing;
    } vram_resp_t;

    function automatic logic [10:0] nt_index(input logic [VA_W-1:0] a, input logic [1:0] mode);
        logic [10:0] idx;
        case (mode)
            MIR_HORIZ:     idx = {a[11], a[9:0]};
            MIR_VERT:      idx = a[10:0];
            MIR_SINGLE_LO: idx = {1'b0, a[9:0]};
            MIR_SINGLE_HI: idx = {1'b1, a[9:0]};
            default:       idx = a[10:0];
        endcase
        return idx;
    endfunction

    // Entries 0x10, 0x14, 0x18 and 0x1C share their cells with 0x00, 0x04, 0x08, 0x0C.
    function automatic logic [PAL_AW-1:0] pal_index(input logic [VA_W-1:0] a);
        logic [PAL_AW-1:0] idx;
        idx = a[PAL_AW-1:0];
        if (idx[4] && (idx[1:0] == 2'b00))
            idx[4] = 1'b0;
        return idx;
    endfunction

endpackage

// File: hdl/vrp_vram.sv
// Video memory: pattern RAM, nametable RAM with mirroring and palette RAM with aliases.
// Runs a clearing pass over pattern and nametable RAM after reset. Depends on vrp_pkg.
module vrp_vram (
    input  logic                clk,
    input  logic                rst_n,
    input  vrp_pkg::vram_req_t  req,
    output vrp_pkg::vram_resp_t resp
);
    import vrp_pkg::*;

    localparam logic [1:0] RGN_PAT = 2'd0;
    localparam logic [1:0] RGN_NT  = 2'd1;
    localparam logic [1:0] RGN_PAL = 2'd2;

    logic [7:0] pattern_mem [PATTERN_BYTES];
    logic [7:0] nt_mem [NAMETABLE_BYTES];
    logic [7:0] pal_mem [PALETTE_BYTES];

    logic [PALETTE_BYTES-1:0] pal_valid_reg;
    logic [PAT_AW-1:0]        clr_cnt_reg;
    logic                     clearing_reg;
    logic [1:0]               region_reg;
    logic [7:0]               pat_q_reg;
    logic [7:0]               nt_q_reg;
    logic [7:0]               pal_q_reg;
    logic                     pal_vq_reg;

    logic [1:0]        region;
    logic [PAT_AW-1:0] pat_idx;
    logic [NT_AW-1:0]  nt_idx;
    logic [PAL_AW-1:0] pal_idx;
    logic              pat_we;
    logic              nt_we;
    logic              pal_we;
    logic [7:0]        mem_wdata;

    always_comb
    begin
        if (!req.addr[13])
            region = RGN_PAT;
        else if (req.addr[13:8] == 6'h3F)
            region = RGN_PAL;
        else
            region = RGN_NT;
    end

    // The nametable index ignores address bit 12, so the byte 0x1000 below a palette
    // address comes from the same nametable entry as the address itself.
    always_comb
    begin
        pal_idx = pal_index(req.addr);
        if (clearing_reg)
        begin
            pat_idx   = clr_cnt_reg;
            nt_idx    = clr_cnt_reg[NT_AW-1:0];
            pat_we    = 1'b1;
            nt_we     = ({1'b0, clr_cnt_reg} < (PAT_AW+1)'(NAMETABLE_BYTES));
            pal_we    = 1'b0;
            mem_wdata = 8'h00;
        end
        else
        begin
            pat_idx   = req.addr[PAT_AW-1:0];
            nt_idx    = NT_AW'(nt_index(req.addr, req.mirroring));
            pat_we    = req.wr_en && (region == RGN_PAT);
            nt_we     = req.wr_en && (region == RGN_NT);
            pal_we    = req.wr_en && (region == RGN_PAL);
            mem_wdata = req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
            pattern_mem[pat_idx] <= mem_wdata;
        pat_q_reg <= pattern_mem[pat_idx];
    end

    always_ff @(posedge clk)
    begin
        if (nt_we)
            nt_mem[nt_idx] <= mem_wdata;
        nt_q_reg <= nt_mem[nt_idx];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[pal_idx] <= mem_wdata;
        pal_q_reg <= pal_mem[pal_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            pal_vq_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            clearing_reg  <= 1'b1;
            region_reg    <= RGN_PAT;
        end
        else
        begin
            if (pal_we)
                pal_valid_reg[pal_idx] <= 1'b1;
            pal_vq_reg <= pal_valid_reg[pal_idx];
            if (req.rd_en)
                region_reg <= region;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PAT_AW'(PATTERN_BYTES - 1))
                    clearing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        case (region_reg)
            RGN_PAT: resp.data = pat_q_reg;
            RGN_PAL: resp.data = pal_vq_reg ? pal_q_reg : 8'h00;
            default: resp.data = nt_q_reg;
        endcase
        resp.nt_data  = nt_q_reg;
        resp.clearing = clearing_reg;
    end

endmodule

// File: hdl/video_register_port_with_vram.sv
// Top level of the video register port: register file, sprite memory and sequencer.
// Instantiates vrp_vram; depends on vrp_pkg.
//
//   channel   ports                          handshake
//   command   start, busy, cmd               taken when start is high and busy is low
//   result    done, result                   done high for one cycle, cannot be held off
//   config    cfg_valid, cfg_ready, cfg_data taken when cfg_valid and cfg_ready are high
//
// In each transaction the memories are read on the accepting edge and the result is
// registered on the following edge, so busy stays high until then. The result appears
// with done in the same cycle as busy falls; a new transaction may start then.
// After reset a clearing pass zeroes pattern and nametable RAM, with busy held high;
// configuration writes are taken at all times.
module video_register_port_with_vram (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vrp_pkg::vrp_in_t cmd,
    output logic             done,
    output vrp_pkg::vrp_out_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_data
);
    import vrp_pkg::*;

    localparam logic [1:0] SEL_HOLD   = 2'd0;
    localparam logic [1:0] SEL_SPRITE = 2'd1;
    localparam logic [1:0] SEL_DATA   = 2'd2;

    logic [1:0]      mirror_reg;
    logic [7:0]      control_reg, control_next;
    logic [7:0]      mask_reg, mask_next;
    logic [7:0]      status_reg, status_next;
    logic [7:0]      spr_addr_reg, spr_addr_next;
    logic [14:0]     temp_addr_reg, temp_addr_next;
    logic [VA_W-1:0] cur_addr_reg, cur_addr_next;
    logic [2:0]      fine_x_reg, fine_x_next;
    logic            toggle_reg, toggle_next;
    logic [7:0]      read_buf_reg, read_buf_next;

    logic            pending_reg;
    logic [1:0]      sel_reg, sel_next;
    logic [7:0]      hold_rdata_reg, hold_rdata_next;
    logic            hold_nmi_reg, hold_nmi_next;
    logic            pal_rgn_reg;
    logic            done_reg;
    vrp_out_t        result_reg, result_next;

    logic [7:0]                  sprite_mem [SPRITE_MEM_BYTES];
    logic [SPRITE_MEM_BYTES-1:0] spr_valid_reg;
    logic [7:0]                  spr_q_reg;
    logic                        spr_vq_reg;

    logic       accept;
    logic       spr_we;
    logic [7:0] step;
    vram_req_t  vreq;
    vram_resp_t vresp;

    assign busy      = pending_reg || vresp.clearing;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign step      = control_reg[2] ? 8'd32 : 8'd1;

    assign spr_we = accept && (cmd.opcode == OP_WRITE) && (cmd.reg_addr == REG_SPR_DAT)
                    && (cmd.scanline > 9'd239) && (cmd.scanline != 9'd241);

    always_comb
    begin
        vreq.rd_en     = accept && (cmd.opcode == OP_READ) && (cmd.reg_addr == REG_DATA);
        vreq.wr_en     = accept && (cmd.opcode == OP_WRITE) && (cmd.reg_addr == REG_DATA);
        vreq.addr      = cur_addr_reg;
        vreq.wdata     = cmd.wdata;
        vreq.mirroring = mirror_reg;
    end

    vrp_vram u_vram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (vreq),
        .resp  (vresp)
    );

    always_ff @(posedge clk)
    begin
        if (spr_we)
            sprite_mem[spr_addr_reg] <= cmd.wdata;
        spr_q_reg <= sprite_mem[spr_addr_reg];
    end

    always_comb
    begin
        control_next    = control_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        spr_addr_next   = spr_addr_reg;
        temp_addr_next  = temp_addr_reg;
        cur_addr_next   = cur_addr_reg;
        fine_x_next     = fine_x_reg;
        toggle_next     = toggle_reg;
        read_buf_next   = read_buf_reg;
        sel_next        = SEL_HOLD;
        hold_rdata_next = 8'h00;
        hold_nmi_next   = 1'b0;
        result_next     = '0;

        if (accept)
        begin
            case (cmd.opcode)
                OP_READ:
                begin
                    case (cmd.reg_addr)
                        REG_CTRL:    hold_rdata_next = control_reg;
                        REG_MASK:    hold_rdata_next = mask_reg;
                        REG_STATUS:
                        begin
                            hold_rdata_next = status_reg;
                            status_next[7]  = 1'b0;
                            toggle_next     = 1'b0;
                        end
                        REG_SPR_ADR: hold_rdata_next = spr_addr_reg;
                        REG_SPR_DAT: sel_next = SEL_SPRITE;
                        REG_DATA:
                        begin
                            sel_next        = SEL_DATA;
                            hold_rdata_next = read_buf_reg;
                            cur_addr_next   = cur_addr_reg + VA_W'(step);
                        end
                        default:     hold_rdata_next = 8'h00;
                    endcase
                end
                OP_WRITE:
                begin
                    case (cmd.reg_addr)
                        REG_CTRL:
                        begin
                            temp_addr_next[11:10] = cmd.wdata[1:0];
                            control_next          = cmd.wdata;
                        end
                        REG_MASK:    mask_next = cmd.wdata;
                        REG_STATUS:  status_next[6:0] = cmd.wdata[6:0];
                        REG_SPR_ADR: spr_addr_next = cmd.wdata;
                        REG_SPR_DAT:
                        begin
                            if (spr_we)
                                spr_addr_next = spr_addr_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_addr_next[4:0] = cmd.wdata[7:3];
                                fine_x_next         = cmd.wdata[2:0];
                                toggle_next         = 1'b1;
                            end
                            else
                            begin
                                temp_addr_next[14:12] = cmd.wdata[2:0];
                                temp_addr_next[9:5]   = cmd.wdata[7:3];
                                toggle_next           = 1'b0;
                            end
                        end
                        REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_addr_next[14]   = 1'b0;
                                temp_addr_next[13:8] = cmd.wdata[5:0];
                                toggle_next          = 1'b1;
                            end
                            else
                            begin
                                temp_addr_next[7:0] = cmd.wdata;
                                cur_addr_next       = {temp_addr_reg[13:8], cmd.wdata};
                                toggle_next         = 1'b0;
                            end
                        end
                        default:     cur_addr_next = cur_addr_reg + VA_W'(step);
                    endcase
                end
                OP_VBLANK:
                begin
                    status_next[7] = 1'b1;
                    hold_nmi_next  = control_reg[7];
                end
                default:     status_next[7:5] = 3'b000;
            endcase
        end

        // While pending: memory data is available, so the result and the read buffer settle.
        if (pending_reg)
        begin
            result_next.nmi_raise = hold_nmi_reg;
            case (sel_reg)
                SEL_SPRITE: result_next.rdata = spr_vq_reg ? spr_q_reg : 8'h00;
                SEL_DATA:
                begin
                    if (pal_rgn_reg)
                    begin
                        result_next.rdata = mask_reg[0] ? (vresp.data & 8'h30) : vresp.data;
                        read_buf_next     = vresp.nt_data;
                    end
                    else
                    begin
                        result_next.rdata = hold_rdata_reg;
                        read_buf_next     = vresp.data;
                    end
                end
                default:    result_next.rdata = hold_rdata_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg    <= MIR_HORIZ;
            control_reg   <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            spr_addr_reg  <= '0;
            temp_addr_reg <= '0;
            cur_addr_reg  <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            read_buf_reg  <= '0;
            pending_reg   <= 1'b0;
            done_reg      <= 1'b0;
            spr_valid_reg <= '0;
            spr_vq_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mirror_reg <= cfg_data;
            control_reg   <= control_next;
            mask_reg      <= mask_next;
            status_reg    <= status_next;
            spr_addr_reg  <= spr_addr_next;
            temp_addr_reg <= temp_addr_next;
            cur_addr_reg  <= cur_addr_next;
            fine_x_reg    <= fine_x_next;
            toggle_reg    <= toggle_next;
            read_buf_reg  <= read_buf_next;
            pending_reg   <= accept;
            done_reg      <= pending_reg;
            if (spr_we)
                spr_valid_reg[spr_addr_reg] <= 1'b1;
            spr_vq_reg <= spr_valid_reg[spr_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            sel_reg        <= sel_next;
            hold_rdata_reg <= hold_rdata_next;
            hold_nmi_reg   <= hold_nmi_next;
            pal_rgn_reg    <= (cur_addr_reg[13:8] == 6'h3F);
        end
    end

endmodule
